/* rtl/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the button debounce classifier
// Event and phase codes, register indexes, reset values and the result struct.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int unsigned DEB_W   = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned PRESS_W = 8;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 16;

  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

  localparam logic [CFG_AW-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CLICK_GAP_TICKS  = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_TICKS_RST   = 8'd3;
  localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = 16'd100;
  localparam logic [TICK_W-1:0] CLICK_GAP_TICKS_RST  = 16'd30;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_CLICK   = 3'd4,
    EV_HOLD    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2,
    PH_HOLD     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [PRESS_W-1:0] click_count;
    logic               event_fired;
    event_t             event_code;
  } result_t;

endpackage

/* rtl/bdc_debounce.sv */
// ----------------------------------------------------------------------------
// bdc_debounce: raw level debouncer
// Accepts a level change once it has persisted for the configured tick count.
// ----------------------------------------------------------------------------
module bdc_debounce (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     raw_level,
  input  logic [bdc_pkg::DEB_W-1:0] debounce_ticks,
  output logic                     level
);

  logic                      stable_level;
  logic                      stable_level_next;
  logic [bdc_pkg::DEB_W-1:0] debounce_count;
  logic [bdc_pkg::DEB_W-1:0] debounce_count_next;
  logic [bdc_pkg::DEB_W-1:0] count_inc;

  assign count_inc = debounce_count + 1'b1;

  always_comb begin
    stable_level_next   = stable_level;
    debounce_count_next = '0;
    if (raw_level != stable_level) begin
      // A threshold of zero passes the compare at once, same as one.
      if (count_inc >= debounce_ticks) begin
        stable_level_next = raw_level;
      end else begin
        debounce_count_next = count_inc;
      end
    end
  end

  assign level = stable_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level   <= 1'b0;
      debounce_count <= '0;
    end else if (step) begin
      stable_level   <= stable_level_next;
      debounce_count <= debounce_count_next;
    end
  end

endmodule

/* rtl/bdc_classifier.sv */
// ----------------------------------------------------------------------------
// bdc_classifier: press, release, click, long press and hold state machine
// Keeps the phase, the saturating tick and press counters and the held event.
// ----------------------------------------------------------------------------
module bdc_classifier (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      level,
  input  logic [bdc_pkg::TICK_W-1:0] long_press_ticks,
  input  logic [bdc_pkg::TICK_W-1:0] click_gap_ticks,
  output bdc_pkg::result_t          result
);

  bdc_pkg::phase_t              phase;
  bdc_pkg::phase_t              phase_next;
  bdc_pkg::event_t              current_event;
  bdc_pkg::event_t              event_next;
  logic                         fired;
  logic [bdc_pkg::TICK_W-1:0]   tick_count;
  logic [bdc_pkg::TICK_W-1:0]   tick_count_next;
  logic [bdc_pkg::TICK_W-1:0]   tick_inc;
  logic [bdc_pkg::PRESS_W-1:0]  press_count;
  logic [bdc_pkg::PRESS_W-1:0]  press_count_next;
  logic [bdc_pkg::PRESS_W-1:0]  press_inc;

  assign tick_inc = (phase != bdc_pkg::PH_IDLE && tick_count != bdc_pkg::TICK_MAX) ?
                    tick_count + 1'b1 : tick_count;
  assign press_inc = (press_count != bdc_pkg::PRESS_MAX) ? press_count + 1'b1 : press_count;

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      bdc_pkg::PH_IDLE: begin
        if (level) phase_next = bdc_pkg::PH_PRESSED;
      end
      bdc_pkg::PH_PRESSED: begin
        if (!level) phase_next = bdc_pkg::PH_RELEASED;
        else if (tick_inc >= long_press_ticks) phase_next = bdc_pkg::PH_HOLD;
      end
      bdc_pkg::PH_RELEASED: begin
        if (level) phase_next = bdc_pkg::PH_PRESSED;
        else if (tick_inc >= click_gap_ticks) phase_next = bdc_pkg::PH_IDLE;
      end
      bdc_pkg::PH_HOLD: begin
        if (!level) phase_next = bdc_pkg::PH_IDLE;
      end
      default: phase_next = bdc_pkg::PH_IDLE;
    endcase
  end

  // Event and counter updates.
  always_comb begin
    event_next       = current_event;
    fired            = 1'b0;
    press_count_next = press_count;
    tick_count_next  = tick_inc;
    case (phase)
      bdc_pkg::PH_IDLE: begin
        if (level) begin
          event_next       = bdc_pkg::EV_PRESS;
          fired            = 1'b1;
          press_count_next = press_inc;
          tick_count_next  = '0;
        end else begin
          event_next = bdc_pkg::EV_NONE;
        end
      end
      bdc_pkg::PH_PRESSED: begin
        if (!level) begin
          event_next      = bdc_pkg::EV_RELEASE;
          fired           = 1'b1;
          tick_count_next = '0;
        end else if (tick_inc >= long_press_ticks) begin
          event_next       = bdc_pkg::EV_LONG;
          fired            = 1'b1;
          press_count_next = '0;
          tick_count_next  = '0;
        end
      end
      bdc_pkg::PH_RELEASED: begin
        if (level) begin
          event_next       = bdc_pkg::EV_PRESS;
          fired            = 1'b1;
          press_count_next = press_inc;
          tick_count_next  = '0;
        end else if (tick_inc >= click_gap_ticks) begin
          event_next       = bdc_pkg::EV_CLICK;
          fired            = 1'b1;
          press_count_next = '0;
          tick_count_next  = '0;
        end
      end
      bdc_pkg::PH_HOLD: begin
        fired = 1'b1;
        if (level) begin
          event_next = bdc_pkg::EV_HOLD;
        end else begin
          event_next       = bdc_pkg::EV_RELEASE;
          press_count_next = '0;
          tick_count_next  = '0;
        end
      end
      default: begin
        event_next = bdc_pkg::EV_NONE;
      end
    endcase
  end

  assign result.event_code  = event_next;
  assign result.event_fired = fired;
  assign result.click_count = press_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bdc_pkg::PH_IDLE;
      current_event <= bdc_pkg::EV_NONE;
      tick_count    <= '0;
      press_count   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      current_event <= event_next;
      tick_count    <= tick_count_next;
      press_count   <= press_count_next;
    end
  end

  // The holding phase raises an event on every tick it spends there.
  a_hold_fires: assert property (@(posedge clk) disable iff (rst)
    (step && phase == bdc_pkg::PH_HOLD) |-> result.event_fired)
    else $error("hold phase tick without a fired event");

  // A fired beat never carries the no-event code.
  a_fired_has_event: assert property (@(posedge clk) disable iff (rst)
    (step && result.event_fired) |-> (result.event_code != bdc_pkg::EV_NONE))
    else $error("fired flag with no event code");

  // State only moves on a processed tick.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(phase) && $stable(tick_count) && $stable(press_count)))
    else $error("classifier state changed without a tick");

  // Entering the holding phase starts a fresh click sequence.
  a_long_clears: assert property (@(posedge clk) disable iff (rst)
    (step && phase == bdc_pkg::PH_PRESSED && phase_next == bdc_pkg::PH_HOLD)
    |=> (press_count == '0 && tick_count == '0))
    else $error("long press did not clear the counters");

endmodule

/* rtl/button_debounce_click_fsm.sv */
// ----------------------------------------------------------------------------
// button_debounce_click_fsm: debounced button event classifier
// One beat per scan tick in, one result beat per tick out.
// ----------------------------------------------------------------------------
// An accepted input beat is held in the input register and its result in the
// result register on m_tdata. Throughput: one beat per cycle while m_tready is
// high; the two registers form a two-stage pipeline, so a new tick enters
// while a result waits. Reset (synchronous, rst high) clears both stages, the
// debounce and event state, and loads the register reset values.
module button_debounce_click_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [0] raw_level, [7:1] ignored
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,  // [2:0] event_code, [3] event_fired,
                                                // [11:4] click_count, [15:12] zero
  input  logic                        cfg_we,
  input  logic [bdc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [bdc_pkg::CFG_DW-1:0]  cfg_wdata
);

  logic [bdc_pkg::DEB_W-1:0]  debounce_ticks;
  logic [bdc_pkg::TICK_W-1:0] long_press_ticks;
  logic [bdc_pkg::TICK_W-1:0] click_gap_ticks;

  logic             in_valid;
  logic             in_raw;
  logic             advance;
  logic             level;
  bdc_pkg::result_t result;
  bdc_pkg::result_t out_res;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bdc_pkg::DEBOUNCE_TICKS_RST;
      long_press_ticks <= bdc_pkg::LONG_PRESS_TICKS_RST;
      click_gap_ticks  <= bdc_pkg::CLICK_GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bdc_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_wdata[bdc_pkg::DEB_W-1:0];
        bdc_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_wdata;
        bdc_pkg::REG_CLICK_GAP_TICKS:  click_gap_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held tick moves on when the result register is free or being drained.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata[0];
    end
  end

  bdc_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .raw_level      (in_raw),
    .debounce_ticks (debounce_ticks),
    .level          (level)
  );

  bdc_classifier u_classifier (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .level            (level),
    .long_press_ticks (long_press_ticks),
    .click_gap_ticks  (click_gap_ticks),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res};

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for button_debounce_click_fsm
// Scan-tick beats go in on the slave stream and event results are checked on
// the master stream against a cycle-free predictor of the debounce and the
// click / long-press classifier. Directed ticks, extreme settings, click count
// saturation and random bouncing sequences run; all but the extreme settings run under random stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [bdc_pkg::CFG_AW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 40000;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata   = '0;  // [0] raw_level, [7:1] ignored
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [15:0]                m_tdata;         // [2:0] event_code, [3] event_fired,
                                               // [11:4] click_count, [15:12] zero
  logic                       cfg_we    = 1'b0;
  logic [bdc_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [bdc_pkg::CFG_DW-1:0] cfg_wdata = '0;

  button_debounce_click_fsm u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predictor copy of the registers and the classifier state.
  logic [bdc_pkg::DEB_W-1:0]   deb_cfg;
  logic [bdc_pkg::TICK_W-1:0]  long_cfg;
  logic [bdc_pkg::TICK_W-1:0]  gap_cfg;
  logic                        stable_lvl;
  logic [bdc_pkg::DEB_W-1:0]   deb_cnt;
  bdc_pkg::phase_t             cur_phase;
  logic [bdc_pkg::TICK_W-1:0]  ticks;
  logic [bdc_pkg::PRESS_W-1:0] presses;
  bdc_pkg::event_t             cur_event;

  bdc_pkg::result_t expected_events[$];
  bdc_pkg::result_t want;
  bdc_pkg::result_t got;
  int               mismatches = 0;
  bit               idle_on    = 1'b1;

  function automatic bdc_pkg::result_t classify_tick(input logic raw);
    bdc_pkg::result_t res;
    logic             fired;
    fired = 1'b0;
    if (raw != stable_lvl) begin
      deb_cnt = deb_cnt + 1'b1;
      // A zero debounce setting accepts the change on its first tick.
      if (deb_cnt >= deb_cfg) begin
        stable_lvl = raw;
        deb_cnt    = '0;
      end
    end else begin
      deb_cnt = '0;
    end
    if (cur_phase != bdc_pkg::PH_IDLE && ticks != bdc_pkg::TICK_MAX) ticks = ticks + 1'b1;
    case (cur_phase)
      bdc_pkg::PH_IDLE: begin
        if (stable_lvl) begin
          cur_event = bdc_pkg::EV_PRESS;
          fired     = 1'b1;
          if (presses != bdc_pkg::PRESS_MAX) presses = presses + 1'b1;
          ticks     = '0;
          cur_phase = bdc_pkg::PH_PRESSED;
        end else begin
          cur_event = bdc_pkg::EV_NONE;
        end
      end
      bdc_pkg::PH_PRESSED: begin
        if (!stable_lvl) begin
          cur_event = bdc_pkg::EV_RELEASE;
          fired     = 1'b1;
          ticks     = '0;
          cur_phase = bdc_pkg::PH_RELEASED;
        end else if (ticks >= long_cfg) begin
          cur_event = bdc_pkg::EV_LONG;
          fired     = 1'b1;
          presses   = '0;
          ticks     = '0;
          cur_phase = bdc_pkg::PH_HOLD;
        end
      end
      bdc_pkg::PH_RELEASED: begin
        if (stable_lvl) begin
          cur_event = bdc_pkg::EV_PRESS;
          fired     = 1'b1;
          if (presses != bdc_pkg::PRESS_MAX) presses = presses + 1'b1;
          ticks     = '0;
          cur_phase = bdc_pkg::PH_PRESSED;
        end else if (ticks >= gap_cfg) begin
          cur_event = bdc_pkg::EV_CLICK;
          fired     = 1'b1;
          presses   = '0;
          ticks     = '0;
          cur_phase = bdc_pkg::PH_IDLE;
        end
      end
      default: begin
        fired = 1'b1;
        if (stable_lvl) begin
          cur_event = bdc_pkg::EV_HOLD;
        end else begin
          cur_event = bdc_pkg::EV_RELEASE;
          presses   = '0;
          ticks     = '0;
          cur_phase = bdc_pkg::PH_IDLE;
        end
      end
    endcase
    res.event_code  = cur_event;
    res.event_fired = fired;
    res.click_count = presses;
    return res;
  endfunction

  task automatic reset_model();
    deb_cfg    = bdc_pkg::DEBOUNCE_TICKS_RST;
    long_cfg   = bdc_pkg::LONG_PRESS_TICKS_RST;
    gap_cfg    = bdc_pkg::CLICK_GAP_TICKS_RST;
    stable_lvl = 1'b0;
    deb_cnt    = '0;
    cur_phase  = bdc_pkg::PH_IDLE;
    ticks      = '0;
    presses    = '0;
    cur_event  = bdc_pkg::EV_NONE;
  endtask

  // s_tvalid stays high between back-to-back beats; it is lowered only in a
  // gap or when the stream goes quiet.
  task automatic send_tick(input logic [7:0] data);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 8) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    // s_tready settles after a rising edge and holds until the next one.
    @(negedge clk);
    while (s_tready !== 1'b1) @(negedge clk);
    @(posedge clk);
    expected_events.push_back(classify_tick(data[0]));
  endtask

  task automatic send_level(input logic lvl, input int unsigned count);
    repeat (count) send_tick({7'b0, lvl});
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdc_pkg::CFG_AW-1:0] addr,
                           input logic [bdc_pkg::CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      bdc_pkg::REG_DEBOUNCE_TICKS:   deb_cfg  = value[bdc_pkg::DEB_W-1:0];
      bdc_pkg::REG_LONG_PRESS_TICKS: long_cfg = value;
      bdc_pkg::REG_CLICK_GAP_TICKS:  gap_cfg  = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    // Reset settings: ignored upper data bits, a short bounce, then a press.
    send_tick(8'hFE);
    send_tick(8'hFE);
    send_level(1'b1, 2);
    send_level(1'b0, 1);
    send_tick(8'hFF);
    send_level(1'b1, 2);
    wait_quiet();
    // Zero debounce and zero thresholds; upper write bits and the unused
    // register index must have no effect.
    write_reg(bdc_pkg::REG_DEBOUNCE_TICKS, 16'hFF00);
    write_reg(bdc_pkg::REG_LONG_PRESS_TICKS, 16'd0);
    write_reg(bdc_pkg::REG_CLICK_GAP_TICKS, 16'd0);
    write_reg(REG_UNUSED, 16'h1234);
    send_level(1'b0, 2);
    send_level(1'b1, 3);
    send_level(1'b0, 2);
    send_level(1'b1, 1);
    send_level(1'b0, 1);
    send_level(1'b1, 1);
    send_level(1'b0, 2);
    wait_quiet();
  endtask

  task automatic test_extreme_settings();
    idle_on = 1'b0;
    write_reg(bdc_pkg::REG_DEBOUNCE_TICKS, 16'd255);
    write_reg(bdc_pkg::REG_LONG_PRESS_TICKS, 16'hFFFF);
    write_reg(bdc_pkg::REG_CLICK_GAP_TICKS, 16'hFFFF);
    send_level(1'b1, 256);
    send_level(1'b0, 4);
    wait_quiet();
    idle_on = 1'b1;
  endtask

  task automatic test_click_saturation();
    write_reg(bdc_pkg::REG_DEBOUNCE_TICKS, 16'd1);
    write_reg(bdc_pkg::REG_LONG_PRESS_TICKS, 16'd1000);
    write_reg(bdc_pkg::REG_CLICK_GAP_TICKS, 16'd20);
    repeat (260) begin
      send_level(1'b1, 1);
      send_level(1'b0, 1);
    end
    send_level(1'b0, 24);
    wait_quiet();
  endtask

  task automatic test_random_sequences();
    int unsigned sent;
    logic        lvl;
    lvl = 1'b0;
    for (int p = 0; p < 2; p++) begin
      write_reg(bdc_pkg::REG_DEBOUNCE_TICKS,
                ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
      write_reg(bdc_pkg::REG_LONG_PRESS_TICKS, 16'($urandom_range(0, 40)));
      write_reg(bdc_pkg::REG_CLICK_GAP_TICKS, 16'($urandom_range(0, 40)));
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 4) != 0) begin
          // Contact bounce around a level change, then a steady run.
          lvl = ~lvl;
          repeat ($urandom_range(0, 2)) begin
            send_level(lvl, 1);
            send_level(~lvl, 1);
            sent += 2;
          end
          repeat ($urandom_range(1, 60)) begin
            send_level(lvl, 1);
            sent++;
          end
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_tick(8'($urandom));
            sent++;
          end
        end
      end
      wait_quiet();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= idle_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (expected_events.size() == 0) begin
        $error("result beat with no tick waiting: m_tdata=%h", m_tdata);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        got  = m_tdata[11:0];
        if (got.event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
          mismatches++;
        end
        if (got.event_fired !== want.event_fired) begin
          $error("event_fired: expected %0d, got %0d", want.event_fired, got.event_fired);
          mismatches++;
        end
        if (got.click_count !== want.click_count) begin
          $error("click_count: expected %0d, got %0d", want.click_count, got.click_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_settings();
    test_click_saturation();
    test_random_sequences();
    wait_quiet();
    if (mismatches == 0) begin
      $display("[button_debounce_click_fsm] OK");
    end else begin
      $display("[button_debounce_click_fsm] ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[button_debounce_click_fsm] ERROR");
    $finish;
  end

endmodule
